@@ src/png_unf_pkg.sv @@
package png_unf_pkg;

    localparam int MAX_WIDTH_DEF       = 512;
    localparam int MAX_HEIGHT_DEF      = 512;
    localparam int PALETTE_ENTRIES_DEF = 256;

    // dimension arithmetic: 13 bits hold 4096, 15 bits hold 4096 * 4
    localparam int DIM_W    = 13;
    localparam int STRIDE_W = 15;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 10;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_COLOR_MODE   = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ALPHA_COUNT  = 2'd3;

    localparam logic [7:0] MAX_FILTER_CODE = 8'd4;
    localparam logic [7:0] OPAQUE          = 8'hFF;

    typedef enum logic [1:0] {
        MODE_GRAY    = 2'd0,
        MODE_RGB     = 2'd1,
        MODE_PALETTE = 2'd2,
        MODE_RGBA    = 2'd3
    } color_mode_t;

    typedef enum logic [2:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4
    } filter_t;

    typedef enum logic [1:0] {
        KIND_SAMPLE  = 2'd0,
        KIND_FILTER  = 2'd1,
        KIND_PALETTE = 2'd2,
        KIND_BAD     = 2'd3
    } item_kind_t;

    // one accepted word, as decoded by the sequencer
    typedef struct packed {
        item_kind_t kind;
        filter_t    filter;
        logic [7:0] data;
        logic [1:0] ci;
        logic       pix_end;
        logic [8:0] column;
        logic [8:0] row;
        logic       row_nz;
        logic       last;
        logic [7:0] entry_index;
        logic [7:0] entry_red;
        logic [7:0] entry_green;
        logic [7:0] entry_blue;
        logic [7:0] entry_alpha;
    } seq_item_t;

    // unfiltered word handed to the output stage
    typedef struct packed {
        logic        pal_we;
        logic [7:0]  pal_index;
        logic [23:0] pal_rgb;
        logic [7:0]  pal_alpha;
        logic [7:0]  value;
        logic [23:0] acc;
        logic        transp;
        logic [8:0]  column;
        logic [8:0]  row;
        logic        last;
        logic        bad;
    } pix_word_t;

endpackage

@@ src/png_unf_seq.sv @@
module png_unf_seq #(
    parameter int MAX_WIDTH  = png_unf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = png_unf_pkg::MAX_HEIGHT_DEF,
    localparam int LINE_AW   = $clog2(MAX_WIDTH * 4)
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     accept,
    input  logic                     opcode,
    input  logic [7:0]               data_byte,
    input  logic [7:0]               entry_index,
    input  logic [7:0]               entry_red,
    input  logic [7:0]               entry_green,
    input  logic [7:0]               entry_blue,
    input  logic [7:0]               entry_alpha,
    input  logic [9:0]               image_width,
    input  logic [9:0]               image_height,
    input  png_unf_pkg::color_mode_t color_mode,
    output png_unf_pkg::seq_item_t   item,
    output logic                     load,
    output logic                     line_rd_en,
    output logic [LINE_AW-1:0]       line_addr
);
    import png_unf_pkg::*;

    localparam int SHIFT  = LINE_AW + 1;
    localparam int PROD_W = LINE_AW + SHIFT;
    localparam logic [PROD_W-1:0] RECIP3 = PROD_W'((2 ** SHIFT + 2) / 3);

    logic [LINE_AW-1:0] byte_pos_reg, byte_pos_next;
    logic [8:0]         row_count_reg, row_count_next;
    filter_t            filter_kind_reg, filter_kind_next;
    logic               awaiting_reg, awaiting_next;
    logic               halted_reg, halted_next;

    logic [2:0]          ch;
    logic [DIM_W-1:0]    width_eff;
    logic [DIM_W-1:0]    height_eff;
    logic [STRIDE_W-1:0] stride;
    logic [PROD_W-1:0]   prod;
    logic [LINE_AW-1:0]  q3;
    logic [LINE_AW-1:0]  rem3;
    logic [LINE_AW-1:0]  quot;
    logic [1:0]          ci;
    logic                row_end;
    logic                img_end;

    always_comb
    begin
        case (color_mode)
            MODE_RGB:  ch = 3'd3;
            MODE_RGBA: ch = 3'd4;
            default:   ch = 3'd1;
        endcase

        width_eff = {3'b000, image_width};
        if (width_eff == '0)
            width_eff = DIM_W'(1);
        else if (width_eff > DIM_W'(MAX_WIDTH))
            width_eff = DIM_W'(MAX_WIDTH);

        height_eff = {3'b000, image_height};
        if (height_eff == '0)
            height_eff = DIM_W'(1);
        else if (height_eff > DIM_W'(MAX_HEIGHT))
            height_eff = DIM_W'(MAX_HEIGHT);

        stride = STRIDE_W'(width_eff) * STRIDE_W'(ch);

        // divide by three through the reciprocal, exact over the whole line
        prod = PROD_W'(byte_pos_reg) * RECIP3;
        q3   = LINE_AW'(prod >> SHIFT);
        rem3 = byte_pos_reg - ((q3 << 1) + q3);

        case (color_mode)
            MODE_RGB:
            begin
                quot = q3;
                ci   = rem3[1:0];
            end
            MODE_RGBA:
            begin
                quot = byte_pos_reg >> 2;
                ci   = byte_pos_reg[1:0];
            end
            default:
            begin
                quot = byte_pos_reg;
                ci   = 2'd0;
            end
        endcase

        row_end = (STRIDE_W'(byte_pos_reg) + STRIDE_W'(1)) >= stride;
        img_end = ({4'b0000, row_count_reg} + DIM_W'(1)) >= height_eff;
    end

    always_comb
    begin
        item             = '0;
        item.filter      = filter_kind_reg;
        item.data        = data_byte;
        item.ci          = ci;
        item.pix_end     = ({1'b0, ci} + 3'd1) == ch;
        item.column      = 9'(quot);
        item.row         = row_count_reg;
        item.row_nz      = row_count_reg != '0;
        item.last        = row_end && img_end;
        item.entry_index = entry_index;
        item.entry_red   = entry_red;
        item.entry_green = entry_green;
        item.entry_blue  = entry_blue;
        item.entry_alpha = entry_alpha;

        byte_pos_next    = byte_pos_reg;
        row_count_next   = row_count_reg;
        filter_kind_next = filter_kind_reg;
        awaiting_next    = awaiting_reg;
        halted_next      = halted_reg;

        if (opcode)
            item.kind = KIND_PALETTE;
        else if (awaiting_reg)
        begin
            if (data_byte > MAX_FILTER_CODE)
            begin
                item.kind   = KIND_BAD;
                halted_next = 1'b1;
            end
            else
            begin
                item.kind        = KIND_FILTER;
                filter_kind_next = filter_t'(data_byte[2:0]);
                awaiting_next    = 1'b0;
                byte_pos_next    = '0;
            end
        end
        else
        begin
            item.kind = KIND_SAMPLE;
            if (row_end)
            begin
                awaiting_next  = 1'b1;
                byte_pos_next  = '0;
                row_count_next = img_end ? 9'd0 : row_count_reg + 9'd1;
            end
            else
                byte_pos_next = byte_pos_reg + LINE_AW'(1);
        end
    end

    // words arriving while halted are swallowed
    assign load       = accept && !halted_reg;
    assign line_rd_en = load && (item.kind == KIND_SAMPLE);
    assign line_addr  = byte_pos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_pos_reg    <= '0;
            row_count_reg   <= '0;
            filter_kind_reg <= FILT_NONE;
            awaiting_reg    <= 1'b1;
            halted_reg      <= 1'b0;
        end
        else if (load)
        begin
            byte_pos_reg    <= byte_pos_next;
            row_count_reg   <= row_count_next;
            filter_kind_reg <= filter_kind_next;
            awaiting_reg    <= awaiting_next;
            halted_reg      <= halted_next;
        end
    end

endmodule

@@ src/png_unf_filter.sv @@
module png_unf_filter #(
    parameter int MAX_WIDTH = png_unf_pkg::MAX_WIDTH_DEF,
    localparam int LINE_AW  = $clog2(MAX_WIDTH * 4)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  png_unf_pkg::seq_item_t item,
    input  logic                   line_rd_en,
    input  logic [LINE_AW-1:0]     line_addr,
    input  logic [8:0]             alpha_count,
    input  logic                   s2_free,
    output logic                   hold,
    output logic                   emit,
    output png_unf_pkg::pix_word_t word
);
    import png_unf_pkg::*;

    localparam int LINE_DEPTH = MAX_WIDTH * 4;

    logic [7:0] line_mem [LINE_DEPTH];
    logic [7:0] line_q_reg;

    logic               s1_valid_reg, s1_valid_next;
    seq_item_t          s1_item_reg;
    logic [LINE_AW-1:0] s1_addr_reg;

    logic [7:0]  left_reg [4];
    logic [7:0]  upl_reg [4];
    logic [23:0] acc_reg, acc_next;

    logic        emit_kind;
    logic        adv;
    logic [7:0]  a, b, c;
    logic [8:0]  sum_ab;
    logic [9:0]  pa, pb, pc;
    logic signed [10:0] d_bc, d_ac, d_abc;
    logic [7:0]  pred;
    logic [7:0]  v;

    assign emit_kind = (s1_item_reg.kind == KIND_BAD) ||
                       ((s1_item_reg.kind == KIND_SAMPLE) && s1_item_reg.pix_end);
    assign adv       = s1_valid_reg && (!emit_kind || s2_free);
    assign hold      = s1_valid_reg && !adv;
    assign emit      = adv && emit_kind;

    always_comb
    begin
        a = left_reg[s1_item_reg.ci];
        b = s1_item_reg.row_nz ? line_q_reg : 8'd0;
        c = upl_reg[s1_item_reg.ci];

        sum_ab = {1'b0, a} + {1'b0, b};

        // Paeth distances: |b-c|, |a-c|, |a+b-2c|
        d_bc  = $signed({3'b000, b}) - $signed({3'b000, c});
        d_ac  = $signed({3'b000, a}) - $signed({3'b000, c});
        d_abc = d_bc + d_ac;
        pa    = d_bc[10]  ? 10'(-d_bc)  : 10'(d_bc);
        pb    = d_ac[10]  ? 10'(-d_ac)  : 10'(d_ac);
        pc    = d_abc[10] ? 10'(-d_abc) : 10'(d_abc);

        case (s1_item_reg.filter)
            FILT_SUB:   pred = a;
            FILT_UP:    pred = b;
            FILT_AVG:   pred = sum_ab[8:1];
            FILT_PAETH:
            begin
                if (pa <= pb && pa <= pc)
                    pred = a;
                else if (pb <= pc)
                    pred = b;
                else
                    pred = c;
            end
            default:    pred = 8'd0;
        endcase

        v = s1_item_reg.data + pred;

        if (s1_item_reg.pix_end)
            acc_next = '0;
        else
        begin
            case (s1_item_reg.ci)
                2'd0:    acc_next = acc_reg | {v, 16'h0000};
                2'd1:    acc_next = acc_reg | {8'h00, v, 8'h00};
                default: acc_next = acc_reg | {16'h0000, v};
            endcase
        end
    end

    always_comb
    begin
        word           = '0;
        word.pal_we    = adv && (s1_item_reg.kind == KIND_PALETTE);
        word.pal_index = s1_item_reg.entry_index;
        word.pal_rgb   = {s1_item_reg.entry_red, s1_item_reg.entry_green,
                          s1_item_reg.entry_blue};
        word.pal_alpha = s1_item_reg.entry_alpha;
        word.value     = v;
        word.acc       = acc_reg;
        word.transp    = {1'b0, v} < alpha_count;
        word.column    = s1_item_reg.column;
        word.row       = s1_item_reg.row;
        word.last      = s1_item_reg.last;
        word.bad       = s1_item_reg.kind == KIND_BAD;
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (load)
            s1_valid_next = 1'b1;
        else if (adv)
            s1_valid_next = 1'b0;
    end

    // line store: read when the byte is taken, written as it leaves stage one
    always_ff @(posedge clk)
    begin
        if (line_rd_en)
            line_q_reg <= line_mem[line_addr];
        if (adv && (s1_item_reg.kind == KIND_SAMPLE))
            line_mem[s1_addr_reg] <= v;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_item_reg <= item;
            s1_addr_reg <= line_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            acc_reg      <= '0;
            for (int i = 0; i < 4; i++)
            begin
                left_reg[i] <= '0;
                upl_reg[i]  <= '0;
            end
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (adv && (s1_item_reg.kind == KIND_FILTER))
            begin
                acc_reg <= '0;
                for (int i = 0; i < 4; i++)
                begin
                    left_reg[i] <= '0;
                    upl_reg[i]  <= '0;
                end
            end
            else if (adv && (s1_item_reg.kind == KIND_SAMPLE))
            begin
                acc_reg                  <= acc_next;
                left_reg[s1_item_reg.ci] <= v;
                upl_reg[s1_item_reg.ci]  <= b;
            end
        end
    end

endmodule

@@ src/png_unf_out.sv @@
module png_unf_out #(
    parameter int PALETTE_ENTRIES = png_unf_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     emit,
    input  png_unf_pkg::pix_word_t   word,
    input  png_unf_pkg::color_mode_t color_mode,
    input  logic                     out_stall,
    output logic                     s2_free,
    output logic                     out_valid,
    output logic [7:0]               red,
    output logic [7:0]               green,
    output logic [7:0]               blue,
    output logic [7:0]               alpha,
    output logic [8:0]               column,
    output logic [8:0]               row,
    output logic                     last_pixel,
    output logic                     bad_filter
);
    import png_unf_pkg::*;

    localparam int PAL_AW = $clog2(PALETTE_ENTRIES);

    logic [31:0] pal_mem [PALETTE_ENTRIES];
    logic [31:0] pal_q_reg;

    logic      s2_valid_reg, s2_valid_next;
    pix_word_t s2_word_reg;
    logic      s2_inrange_reg;

    logic wr_inrange;
    logic rd_inrange;

    assign wr_inrange = {1'b0, word.pal_index} < 9'(PALETTE_ENTRIES);
    assign rd_inrange = {1'b0, word.value} < 9'(PALETTE_ENTRIES);

    assign s2_free   = !s2_valid_reg || !out_stall;
    assign out_valid = s2_valid_reg;

    always_ff @(posedge clk)
    begin
        if (word.pal_we && wr_inrange)
            pal_mem[word.pal_index[PAL_AW-1:0]] <= {word.pal_rgb, word.pal_alpha};
        if (emit)
            pal_q_reg <= pal_mem[word.value[PAL_AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            s2_word_reg    <= word;
            s2_inrange_reg <= rd_inrange;
        end
    end

    always_comb
    begin
        s2_valid_next = s2_valid_reg;
        if (emit)
            s2_valid_next = 1'b1;
        else if (!out_stall)
            s2_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= s2_valid_next;
    end

    always_comb
    begin
        red   = s2_word_reg.value;
        green = s2_word_reg.value;
        blue  = s2_word_reg.value;
        alpha = OPAQUE;
        case (color_mode)
            MODE_RGB:
            begin
                red   = s2_word_reg.acc[23:16];
                green = s2_word_reg.acc[15:8];
            end
            MODE_RGBA:
            begin
                red   = s2_word_reg.acc[23:16];
                green = s2_word_reg.acc[15:8];
                blue  = s2_word_reg.acc[7:0];
                alpha = s2_word_reg.value;
            end
            MODE_PALETTE:
            begin
                // entries beyond the palette read as zero colour, and as zero alpha below the alpha count
                red   = s2_inrange_reg ? pal_q_reg[31:24] : 8'd0;
                green = s2_inrange_reg ? pal_q_reg[23:16] : 8'd0;
                blue  = s2_inrange_reg ? pal_q_reg[15:8]  : 8'd0;
                if (s2_word_reg.transp)
                    alpha = s2_inrange_reg ? pal_q_reg[7:0] : 8'd0;
            end
            default:
            begin
            end
        endcase

        column     = s2_word_reg.column;
        row        = s2_word_reg.row;
        last_pixel = s2_word_reg.last;
        bad_filter = s2_word_reg.bad;

        if (s2_word_reg.bad)
        begin
            red        = 8'd0;
            green      = 8'd0;
            blue       = 8'd0;
            alpha      = 8'd0;
            column     = 9'd0;
            last_pixel = 1'b0;
        end
    end

endmodule

@@ src/png_scanline_unfilter_rgba_top.sv @@
// PNG scanline unfilter, 8-bit samples, RGBA pixel output.
// Input channel (in_valid / in_stall): one word per accepted cycle, either a
// scanline byte (opcode 0; each row is a filter byte then width*channels
// samples) or a palette entry write (opcode 1). Output channel (out_valid /
// out_stall): one RGBA pixel with column, row and last_pixel for each byte
// that completes a pixel, or a single bad_filter word if a filter code above
// four turns up, after which input words are swallowed until reset.
// Throughput: one word per cycle while out_stall is low; each byte makes a
// single read of the one-port-read line store when taken and the write-back
// as it leaves the unfilter stage. out_valid rises once the completing byte
// has left the unfilter stage register and its pixel sits in the output register.
// A stalled result sits in the output register while the unfilter stage
// keeps working; in_stall rises only once both stages hold a word that
// yields a pixel. Configuration is written through cfg_write_en / cfg_index /
// cfg_data while no word is in flight.
// Reset puts the block at the filter byte of row 0 with cleared neighbour
// history. The line store and palette are not cleared: there is no clearing
// pass and the block takes words from the first clock after reset.
module png_scanline_unfilter_rgba_top #(
    parameter int MAX_WIDTH       = png_unf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT      = png_unf_pkg::MAX_HEIGHT_DEF,
    parameter int PALETTE_ENTRIES = png_unf_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write_en,
    input  logic [png_unf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [png_unf_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               opcode,
    input  logic [7:0]                         data_byte,
    input  logic [7:0]                         entry_index,
    input  logic [7:0]                         entry_red,
    input  logic [7:0]                         entry_green,
    input  logic [7:0]                         entry_blue,
    input  logic [7:0]                         entry_alpha,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [7:0]                         red,
    output logic [7:0]                         green,
    output logic [7:0]                         blue,
    output logic [7:0]                         alpha,
    output logic [8:0]                         column,
    output logic [8:0]                         row,
    output logic                               last_pixel,
    output logic                               bad_filter
);
    import png_unf_pkg::*;

    localparam int LINE_AW = $clog2(MAX_WIDTH * 4);

    logic [9:0]  width_reg;
    logic [9:0]  height_reg;
    color_mode_t mode_reg;
    logic [8:0]  alpha_count_reg;

    logic               in_accept;
    seq_item_t          item;
    logic               load;
    logic               line_rd_en;
    logic [LINE_AW-1:0] line_addr;
    logic               hold;
    logic               emit;
    pix_word_t          word;
    logic               s2_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg       <= 10'd1;
            height_reg      <= 10'd1;
            mode_reg        <= MODE_GRAY;
            alpha_count_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg       <= cfg_data;
                REG_IMAGE_HEIGHT: height_reg      <= cfg_data;
                REG_COLOR_MODE:   mode_reg        <= color_mode_t'(cfg_data[1:0]);
                REG_ALPHA_COUNT:  alpha_count_reg <= cfg_data[8:0];
                default:
                begin
                end
            endcase
        end
    end

    assign in_stall  = hold;
    assign in_accept = in_valid && !hold;

    png_unf_seq #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (in_accept),
        .opcode       (opcode),
        .data_byte    (data_byte),
        .entry_index  (entry_index),
        .entry_red    (entry_red),
        .entry_green  (entry_green),
        .entry_blue   (entry_blue),
        .entry_alpha  (entry_alpha),
        .image_width  (width_reg),
        .image_height (height_reg),
        .color_mode   (mode_reg),
        .item         (item),
        .load         (load),
        .line_rd_en   (line_rd_en),
        .line_addr    (line_addr)
    );

    png_unf_filter #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_filter (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (load),
        .item        (item),
        .line_rd_en  (line_rd_en),
        .line_addr   (line_addr),
        .alpha_count (alpha_count_reg),
        .s2_free     (s2_free),
        .hold        (hold),
        .emit        (emit),
        .word        (word)
    );

    png_unf_out #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .emit       (emit),
        .word       (word),
        .color_mode (mode_reg),
        .out_stall  (out_stall),
        .s2_free    (s2_free),
        .out_valid  (out_valid),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .alpha      (alpha),
        .column     (column),
        .row        (row),
        .last_pixel (last_pixel),
        .bad_filter (bad_filter)
    );

endmodule

@@ tb/tb_png_scanline_unfilter_rgba_top.sv @@
module tb_png_scanline_unfilter_rgba_top;
    import png_unf_pkg::*;

    localparam logic OP_SAMPLE  = 1'b0;
    localparam logic OP_PALETTE = 1'b1;

    localparam int LINE_DEPTH  = MAX_WIDTH_DEF * 4;
    localparam int SETTLE      = 8;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 500000;
    localparam int RANDOM_WORDS = 320;
    localparam int RANDOM_PHASES = 8;

    typedef struct {
        logic       op;
        logic [7:0] data;
        logic [7:0] idx;
        logic [7:0] er;
        logic [7:0] eg;
        logic [7:0] eb;
        logic [7:0] ea;
    } word_t;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [8:0] column;
        logic [8:0] row;
        logic       last;
        logic       bad;
    } pixel_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_write_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic                   opcode = 1'b0;
    logic [7:0]             data_byte = '0;
    logic [7:0]             entry_index = '0;
    logic [7:0]             entry_red = '0;
    logic [7:0]             entry_green = '0;
    logic [7:0]             entry_blue = '0;
    logic [7:0]             entry_alpha = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [7:0]             red;
    logic [7:0]             green;
    logic [7:0]             blue;
    logic [7:0]             alpha;
    logic [8:0]             column;
    logic [8:0]             row;
    logic                   last_pixel;
    logic                   bad_filter;

    png_scanline_unfilter_rgba_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .data_byte    (data_byte),
        .entry_index  (entry_index),
        .entry_red    (entry_red),
        .entry_green  (entry_green),
        .entry_blue   (entry_blue),
        .entry_alpha  (entry_alpha),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .alpha        (alpha),
        .column       (column),
        .row          (row),
        .last_pixel   (last_pixel),
        .bad_filter   (bad_filter)
    );

    // words waiting to be offered, and pixels the unfilter mirror expects
    word_t  stream_q[$];
    pixel_t expected_pixels[$];
    word_t  cur_word;

    int mismatches = 0;
    int cycles = 0;
    int queued_words = 0;
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    bit hold_start = 1'b0;
    int hold_left = 0;

    // unfilter mirror state
    logic [7:0]  line_mem [LINE_DEPTH];
    logic [7:0]  left_h [4];
    logic [7:0]  uleft_h [4];
    logic [23:0] pal_rgb [256];
    logic [7:0]  pal_alpha [256];
    logic [23:0] pix_acc;
    int          byte_pos;
    int          row_cnt;
    filter_t     filt;
    bit          await_filter;
    bit          halted_m;

    logic [9:0]  cfg_width;
    logic [9:0]  cfg_height;
    color_mode_t cfg_mode;
    logic [8:0]  cfg_alpha_count;

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int clamp_dim(input logic [9:0] v, input int maxv);
        if (v == 0)
            return 1;
        if (v > maxv)
            return maxv;
        return v;
    endfunction

    function automatic int channels(input color_mode_t m);
        if (m == MODE_RGB)
            return 3;
        if (m == MODE_RGBA)
            return 4;
        return 1;
    endfunction

    function automatic int paeth_pick(input int a, input int b, input int c);
        int p;
        int pa;
        int pb;
        int pc;
        p  = a + b - c;
        pa = (p > a) ? p - a : a - p;
        pb = (p > b) ? p - b : b - p;
        pc = (p > c) ? p - c : c - p;
        if (pa <= pb && pa <= pc)
            return a;
        if (pb <= pc)
            return b;
        return c;
    endfunction

    task automatic reset_mirror();
        foreach (line_mem[i])
            line_mem[i] = '0;
        foreach (pal_rgb[i])
        begin
            pal_rgb[i]   = '0;
            pal_alpha[i] = '0;
        end
        for (int i = 0; i < 4; i++)
        begin
            left_h[i]  = '0;
            uleft_h[i] = '0;
        end
        pix_acc         = '0;
        byte_pos        = 0;
        row_cnt         = 0;
        filt            = FILT_NONE;
        await_filter    = 1'b1;
        halted_m        = 1'b0;
        cfg_width       = 10'd1;
        cfg_height      = 10'd1;
        cfg_mode        = MODE_GRAY;
        cfg_alpha_count = '0;
    endtask

    // advance the mirror by one accepted word
    task automatic unfilter_word(input word_t w);
        int     nch;
        int     stride;
        int     height;
        int     x;
        int     ci;
        int     a;
        int     b;
        int     c;
        int     v;
        bit     emitted;
        pixel_t px;
        px = '{default: '0};
        emitted = 1'b0;
        if (halted_m)
            return;
        if (w.op == OP_PALETTE)
        begin
            pal_rgb[w.idx]   = {w.er, w.eg, w.eb};
            pal_alpha[w.idx] = w.ea;
            return;
        end
        if (await_filter)
        begin
            if (w.data > MAX_FILTER_CODE)
            begin
                px.row = row_cnt[8:0];
                px.bad = 1'b1;
                expected_pixels.push_back(px);
                halted_m = 1'b1;
                return;
            end
            filt         = filter_t'(w.data[2:0]);
            await_filter = 1'b0;
            byte_pos     = 0;
            pix_acc      = '0;
            for (int i = 0; i < 4; i++)
            begin
                left_h[i]  = '0;
                uleft_h[i] = '0;
            end
            return;
        end

        nch    = channels(cfg_mode);
        stride = clamp_dim(cfg_width, MAX_WIDTH_DEF) * nch;
        height = clamp_dim(cfg_height, MAX_HEIGHT_DEF);
        x      = byte_pos;
        ci     = x % nch;
        a      = left_h[ci];
        b      = (row_cnt != 0 && x < LINE_DEPTH) ? int'(line_mem[x]) : 0;
        c      = uleft_h[ci];

        case (filt)
            FILT_SUB:   v = w.data + a;
            FILT_UP:    v = w.data + b;
            FILT_AVG:   v = w.data + ((a + b) >> 1);
            FILT_PAETH: v = w.data + paeth_pick(a, b, c);
            default:    v = w.data;
        endcase
        v = v & 255;

        left_h[ci]  = v[7:0];
        uleft_h[ci] = b[7:0];
        if (x < LINE_DEPTH)
            line_mem[x] = v[7:0];

        if (ci + 1 == nch)
        begin
            px.alpha = OPAQUE;
            case (cfg_mode)
                MODE_GRAY:
                begin
                    px.red   = v[7:0];
                    px.green = v[7:0];
                    px.blue  = v[7:0];
                end
                MODE_PALETTE:
                begin
                    px.red   = pal_rgb[v][23:16];
                    px.green = pal_rgb[v][15:8];
                    px.blue  = pal_rgb[v][7:0];
                    if (v < cfg_alpha_count)
                        px.alpha = pal_alpha[v];
                end
                MODE_RGB:
                begin
                    px.red   = pix_acc[23:16];
                    px.green = pix_acc[15:8];
                    px.blue  = v[7:0];
                end
                default:
                begin
                    px.red   = pix_acc[23:16];
                    px.green = pix_acc[15:8];
                    px.blue  = pix_acc[7:0];
                    px.alpha = v[7:0];
                end
            endcase
            px.column = 9'((x / nch) & 511);
            px.row    = row_cnt[8:0];
            pix_acc   = '0;
            emitted   = 1'b1;
        end
        else
            pix_acc = pix_acc | 24'(v << (16 - 8 * ci));

        // a register change mid row may leave x already past the row length
        if (x + 1 >= stride)
        begin
            await_filter = 1'b1;
            byte_pos     = 0;
            if (row_cnt + 1 >= height)
            begin
                px.last = emitted;
                row_cnt = 0;
            end
            else
                row_cnt = (row_cnt + 1) & 511;
        end
        else
            byte_pos = (x + 1) & 2047;

        if (emitted)
            expected_pixels.push_back(px);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= val;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        case (idx)
            REG_IMAGE_WIDTH:  cfg_width = val;
            REG_IMAGE_HEIGHT: cfg_height = val;
            REG_COLOR_MODE:   cfg_mode = color_mode_t'(val[1:0]);
            default:          cfg_alpha_count = val[8:0];
        endcase
    endtask

    // mode and alpha count carry junk in the unused upper bits
    task automatic setup_image(input logic [9:0] w, input logic [9:0] h,
                               input logic [1:0] m, input logic [8:0] ac);
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(REG_COLOR_MODE, {8'($urandom_range(255)), m});
        write_reg(REG_ALPHA_COUNT, {1'($urandom_range(1)), ac});
    endtask

    task automatic random_setup();
        logic [9:0] wv;
        logic [9:0] hv;
        logic [8:0] ac;
        case ($urandom_range(9))
            0:       wv = 10'd0;
            1:       wv = 10'($urandom_range(9, 24));
            default: wv = 10'($urandom_range(1, 8));
        endcase
        hv = ($urandom_range(7) == 0) ? 10'd0 : 10'($urandom_range(1, 5));
        case ($urandom_range(3))
            0:       ac = 9'd0;
            1:       ac = 9'd256;
            default: ac = 9'($urandom_range(256));
        endcase
        setup_image(wv, hv, 2'($urandom_range(3)), ac);
    endtask

    task automatic push_sample(input logic [7:0] d);
        word_t w;
        w.op   = OP_SAMPLE;
        w.data = d;
        w.idx  = 8'($urandom_range(255));
        w.er   = 8'($urandom_range(255));
        w.eg   = 8'($urandom_range(255));
        w.eb   = 8'($urandom_range(255));
        w.ea   = 8'($urandom_range(255));
        stream_q.push_back(w);
        queued_words++;
    endtask

    task automatic push_filter(input filter_t f);
        push_sample({5'd0, f});
    endtask

    task automatic push_palette(input logic [7:0] idx, input logic [7:0] r,
                                input logic [7:0] g, input logic [7:0] b,
                                input logic [7:0] a);
        word_t w;
        w.op   = OP_PALETTE;
        w.data = 8'($urandom_range(255));
        w.idx  = idx;
        w.er   = r;
        w.eg   = g;
        w.eb   = b;
        w.ea   = a;
        stream_q.push_back(w);
        queued_words++;
    endtask

    task automatic push_random_palette();
        push_palette(8'($urandom_range(255)), 8'($urandom_range(255)),
                     8'($urandom_range(255)), 8'($urandom_range(255)),
                     8'($urandom_range(255)));
    endtask

    function automatic logic [7:0] rand_sample();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // one filtered row at the current settings, palette writes sprinkled in
    task automatic gen_row();
        int stride;
        stride = clamp_dim(cfg_width, MAX_WIDTH_DEF) * channels(cfg_mode);
        push_filter(filter_t'($urandom_range(4)));
        for (int k = 0; k < stride; k++)
        begin
            if ($urandom_range(15) == 0)
                push_random_palette();
            push_sample(rand_sample());
        end
    endtask

    task automatic gen_images(input int min_words);
        int start;
        int rows;
        start = queued_words;
        rows  = clamp_dim(cfg_height, MAX_HEIGHT_DEF);
        do
        begin
            for (int r = 0; r < rows; r++)
                gen_row();
        end
        while (queued_words - start < min_words);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (stream_q.size() != 0 || in_valid || expected_pixels.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic set_idle(input int tx, input int rx);
        tx_idle_pct  = tx;
        rx_stall_pct = rx;
    endtask

    // sender: holds a stalled word, otherwise offers the next one or idles
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!(in_valid && in_stall))
        begin
            if (in_valid)
                unfilter_word(cur_word);
            if (stream_q.size() != 0 && $urandom_range(99) >= tx_idle_pct)
            begin
                cur_word = stream_q.pop_front();
                in_valid    <= 1'b1;
                opcode      <= cur_word.op;
                data_byte   <= cur_word.data;
                entry_index <= cur_word.idx;
                entry_red   <= cur_word.er;
                entry_green <= cur_word.eg;
                entry_blue  <= cur_word.eb;
                entry_alpha <= cur_word.ea;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver stall, with one long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (hold_start)
            begin
                hold_left  = HOLD_CYCLES;
                hold_start = 1'b0;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    always @(posedge clk)
    begin : pixel_check
        pixel_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_pixels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: col %0d row %0d bad %0d",
                             column, row, bad_filter);
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (want.red !== red || want.green !== green || want.blue !== blue ||
                    want.alpha !== alpha || want.column !== column ||
                    want.row !== row || want.last !== last_pixel ||
                    want.bad !== bad_filter)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("exp rgba %0d %0d %0d %0d col %0d row %0d last %0d bad %0d",
                                 want.red, want.green, want.blue, want.alpha,
                                 want.column, want.row, want.last, want.bad);
                        $display("got rgba %0d %0d %0d %0d col %0d row %0d last %0d bad %0d",
                                 red, green, blue, alpha, column, row,
                                 last_pixel, bad_filter);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        reset_mirror();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // gray, one pixel per row, one row per filter
        setup_image(10'd1, 10'd5, MODE_GRAY, 9'd0);
        set_idle(0, 0);
        // every palette entry gets written before any palette read
        for (int i = 0; i < 256; i++)
        begin
            if (i == 0)
                push_palette(8'd0, 8'h00, 8'h00, 8'h00, 8'h00);
            else if (i == 255)
                push_palette(8'd255, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
            else
                push_palette(8'(i), 8'($urandom_range(255)), 8'($urandom_range(255)),
                             8'($urandom_range(255)), 8'($urandom_range(255)));
        end
        push_filter(FILT_PAETH);
        push_sample(8'hFF);
        push_filter(FILT_SUB);
        push_sample(8'h01);
        push_filter(FILT_UP);
        push_sample(8'h01);
        push_filter(FILT_AVG);
        push_sample(8'h80);
        push_filter(FILT_NONE);
        push_sample(8'h00);
        wait_idle();

        // rgba image switched to gray in the middle of row 1
        setup_image(10'd1, 10'd3, MODE_RGBA, 9'd256);
        push_filter(FILT_NONE);
        push_sample(8'h00);
        push_sample(8'hFF);
        push_sample(8'h12);
        push_sample(8'hFF);
        push_filter(FILT_AVG);
        push_sample(8'hFF);
        push_sample(8'h01);
        wait_idle();
        write_reg(REG_COLOR_MODE, {8'd0, MODE_GRAY});
        push_sample(8'h7F);
        push_filter(FILT_PAETH);
        push_sample(8'hFF);
        wait_idle();

        // long receiver hold-off while the sender keeps offering
        set_idle(0, 0);
        setup_image(10'd8, 10'd3, MODE_RGBA, 9'd0);
        gen_images(90);
        hold_start = 1'b1;
        wait_idle();

        // widest row: width saturates to the maximum
        set_idle(0, 53);
        setup_image(10'd1023, 10'd1, MODE_PALETTE, 9'd256);
        gen_images(1);
        wait_idle();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p % 4)
                0:       set_idle(0, 0);
                1:       set_idle(53, 0);
                2:       set_idle(0, 53);
                default: set_idle(28, 28);
            endcase
            random_setup();
            gen_images(RANDOM_WORDS / RANDOM_PHASES);
            wait_idle();
        end

        // bad filter code on row 1, everything after it is swallowed
        set_idle(28, 28);
        setup_image(10'd3, 10'd4, 2'($urandom_range(3)), 9'($urandom_range(256)));
        gen_row();
        push_sample($urandom_range(1) ? 8'd5 : 8'($urandom_range(6, 255)));
        for (int k = 0; k < 30; k++)
        begin
            if ($urandom_range(3) == 0)
                push_random_palette();
            else
                push_sample(8'($urandom_range(255)));
        end
        wait_idle();
        write_reg(REG_ALPHA_COUNT, 10'($urandom_range(256)));
        wait_idle();

        if (mismatches == 0 && expected_pixels.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
